@@ hw/rtl/mgh_pkg.sv @@
// shared types and constants of the multiplicity gate histogram
`default_nettype none
package mgh_pkg;

	localparam int MULT_BINS_DEF     = 64;
	localparam int PENDING_DEPTH_DEF = 64;
	localparam int TIME_WIDTH_DEF    = 48;

	localparam int REG_W      = 32;
	localparam int FIELD_T_W  = 48;
	localparam int IDX_W      = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 120;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PREDELAY  = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONGDELAY = 2'd1;
	localparam logic [IDX_W-1:0] REG_GATE      = 2'd2;

	// input kinds
	localparam logic KIND_EVENT  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_UPD,
		ST_CHECK_FULL,
		ST_RET_RD,
		ST_RET_LATCH,
		ST_HIST_RD,
		ST_HIST_WR,
		ST_INSERT,
		ST_FIN_CHECK,
		ST_OUT_RD,
		ST_OUT_SEND
	} state_t;

	typedef enum logic [1:0] {
		RET_WALK,
		RET_FORCE,
		RET_FINISH
	} ret_mode_t;

	// window decisions for one pending entry
	typedef struct packed {
		logic in_ra;
		logic in_a;
		logic retire;
	} gate_hit_t;

endpackage
`default_nettype wire

@@ hw/rtl/mgh_gate.sv @@
// window compare of one pending entry against the current event time
`default_nettype none
module mgh_gate #(
	parameter int TIME_WIDTH = mgh_pkg::TIME_WIDTH_DEF
) (
	input  wire logic [TIME_WIDTH-1:0]     delta,
	input  wire logic [mgh_pkg::REG_W-1:0] predelay,
	input  wire logic [mgh_pkg::REG_W-1:0] long_delay,
	input  wire logic [mgh_pkg::REG_W-1:0] gate,
	output mgh_pkg::gate_hit_t             hit
);
	localparam int CW = ((TIME_WIDTH > 33) ? TIME_WIDTH : 33) + 1;

	logic [CW-1:0] d_ext;
	logic [CW-1:0] ra_end;
	logic [CW-1:0] a_end;

	// window ends, both inclusive
	always_comb begin
		d_ext  = CW'(delta);
		ra_end = CW'(predelay) + CW'(gate);
		a_end  = CW'(long_delay) + CW'(gate);
		hit.in_ra  = (d_ext >= CW'(predelay)) && (d_ext <= ra_end);
		hit.in_a   = (d_ext >= CW'(long_delay)) && (d_ext <= a_end);
		hit.retire = (d_ext > ra_end) && (d_ext > a_end);
	end
endmodule
`default_nettype wire

@@ hw/rtl/multiplicity_gate_histogram.sv @@
// top level of the multiplicity gate histogram
// Usage: detector event words arrive on the s_ channel, s_tuser = 0 and
// s_tdata = event time, times non-decreasing (a smaller time counts as the
// latest one). s_tuser = 1 is a finish word: every pending event retires,
// then MULT_BINS readout words leave on the m_ channel, one per bin, with
// m_tlast on the final bin, after which the run state returns to zero.
// Gate delays and width are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle.
// An event walks the pending ring: for each pending entry a ring read and
// then an update and write-back, plus a histogram read and write for every
// entry that retires in the walk; a forced retire of the oldest entry when
// the ring stays full; then a last ring check, a full check and the insert.
// The ring and histogram memories have one port pair each, so reads and
// writes of an entry take separate steps.
// A finish retires each pending entry in turn (finish check, ring read,
// latch, histogram read and write), then reads and sends one bin word at a
// time. If m_tready is low the word holds and the block waits; no input is
// taken during a readout.
// Reset clears the fill count, head and histogram valid bits at once; no
// clearing pass is needed.
`default_nettype none
module multiplicity_gate_histogram #(
	parameter int MULT_BINS     = mgh_pkg::MULT_BINS_DEF,
	parameter int PENDING_DEPTH = mgh_pkg::PENDING_DEPTH_DEF,
	parameter int TIME_WIDTH    = mgh_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input word
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [mgh_pkg::IN_DATA_W-1:0]   s_tdata,  // event_time[47:0]
	input  wire logic [0:0]                      s_tuser,  // kind
	// readout word
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// bin_index[5:0], ra_hist_count[37:6], a_hist_count[69:38],
	// last_event_time[117:70], overflow_seen[118], zero[119]
	output logic [mgh_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                 m_tlast,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [mgh_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [mgh_pkg::REG_W-1:0]       cfg_wdata
);
	localparam int AW = $clog2(PENDING_DEPTH);
	localparam int FW = $clog2(PENDING_DEPTH + 1);
	localparam int BW = $clog2(MULT_BINS);
	localparam int HW = mgh_pkg::REG_W;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] t;
		logic [BW-1:0]         ra;
		logic [BW-1:0]         a;
	} ring_entry_t;

	// configuration registers
	logic [HW-1:0] predelay_q, long_delay_q, gate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predelay_q   <= '0;
			long_delay_q <= '0;
			gate_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mgh_pkg::REG_PREDELAY:  predelay_q   <= cfg_wdata;
				mgh_pkg::REG_LONGDELAY: long_delay_q <= cfg_wdata;
				mgh_pkg::REG_GATE:      gate_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mgh_pkg::state_t    state_q, state_d;
	mgh_pkg::ret_mode_t mode_q;

	logic [AW-1:0]          head_q, ptr_q;
	logic [FW-1:0]          fill_q, cnt_q;
	logic                   prefix_q;
	logic [TIME_WIDTH-1:0]  latest_q, cur_t_q;
	logic                   overflow_q;
	logic [BW-1:0]          ra_bin_q, a_bin_q, out_bin_q;
	logic [MULT_BINS-1:0]   ra_valid_q, a_valid_q;

	ring_entry_t ring_mem [PENDING_DEPTH];
	ring_entry_t ring_rd_q;
	logic [HW-1:0] ra_mem [MULT_BINS];
	logic [HW-1:0] a_mem  [MULT_BINS];
	logic [HW-1:0] ra_rd_q, a_rd_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(PENDING_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// input handshake and time of the offered word
	logic                  in_acc;
	logic                  in_finish;
	logic [TIME_WIDTH-1:0] t_in;
	assign in_acc    = s_tvalid && s_tready;
	assign in_finish = (s_tuser[0] == mgh_pkg::KIND_FINISH);
	assign t_in      = TIME_WIDTH'(s_tdata[mgh_pkg::FIELD_T_W-1:0]);

	// insert slot at head + fill, modulo depth
	logic [AW:0]   ins_sum;
	logic [AW-1:0] ins_addr;
	always_comb begin
		ins_sum  = (AW+1)'(head_q) + (AW+1)'(fill_q);
		ins_addr = (ins_sum >= (AW+1)'(PENDING_DEPTH)) ?
			AW'(ins_sum - (AW+1)'(PENDING_DEPTH)) : AW'(ins_sum);
	end

	// window check on the entry just read
	logic [TIME_WIDTH-1:0] delta;
	mgh_pkg::gate_hit_t    hit;
	assign delta = cur_t_q - ring_rd_q.t;

	mgh_gate #(.TIME_WIDTH(TIME_WIDTH)) u_gate (
		.delta      (delta),
		.predelay   (predelay_q),
		.long_delay (long_delay_q),
		.gate       (gate_q),
		.hit        (hit)
	);

	// updated counts of the walked entry
	logic [BW-1:0] ra_new, a_new;
	logic          cnt_sat;
	always_comb begin
		ra_new  = ring_rd_q.ra;
		a_new   = ring_rd_q.a;
		cnt_sat = 1'b0;
		if (hit.in_ra) begin
			if (ring_rd_q.ra >= BW'(MULT_BINS - 1)) cnt_sat = 1'b1;
			else ra_new = ring_rd_q.ra + BW'(1);
		end
		if (hit.in_a) begin
			if (ring_rd_q.a >= BW'(MULT_BINS - 1)) cnt_sat = 1'b1;
			else a_new = ring_rd_q.a + BW'(1);
		end
	end

	// histogram read data, invalid bins read as zero
	logic [HW-1:0] ra_old, a_old;
	logic [HW-1:0] ra_out, a_out;
	assign ra_old = ra_valid_q[ra_bin_q] ? ra_rd_q : '0;
	assign a_old  = a_valid_q[a_bin_q]   ? a_rd_q  : '0;
	assign ra_out = ra_valid_q[out_bin_q] ? ra_rd_q : '0;
	assign a_out  = a_valid_q[out_bin_q]  ? a_rd_q  : '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mgh_pkg::ST_IDLE:
				if (in_acc) state_d = in_finish ? mgh_pkg::ST_FIN_CHECK : mgh_pkg::ST_WALK_RD;
			mgh_pkg::ST_WALK_RD:
				state_d = (cnt_q == '0) ? mgh_pkg::ST_CHECK_FULL : mgh_pkg::ST_WALK_UPD;
			mgh_pkg::ST_WALK_UPD:
				state_d = (prefix_q && hit.retire) ? mgh_pkg::ST_HIST_RD : mgh_pkg::ST_WALK_RD;
			mgh_pkg::ST_CHECK_FULL:
				state_d = (fill_q == FW'(PENDING_DEPTH)) ? mgh_pkg::ST_RET_RD : mgh_pkg::ST_INSERT;
			mgh_pkg::ST_RET_RD:    state_d = mgh_pkg::ST_RET_LATCH;
			mgh_pkg::ST_RET_LATCH: state_d = mgh_pkg::ST_HIST_RD;
			mgh_pkg::ST_HIST_RD:   state_d = mgh_pkg::ST_HIST_WR;
			mgh_pkg::ST_HIST_WR: begin
				unique case (mode_q)
					mgh_pkg::RET_WALK:   state_d = mgh_pkg::ST_WALK_RD;
					mgh_pkg::RET_FORCE:  state_d = mgh_pkg::ST_INSERT;
					mgh_pkg::RET_FINISH: state_d = mgh_pkg::ST_FIN_CHECK;
					default:             state_d = mgh_pkg::ST_IDLE;
				endcase
			end
			mgh_pkg::ST_INSERT: state_d = mgh_pkg::ST_IDLE;
			mgh_pkg::ST_FIN_CHECK:
				state_d = (fill_q != '0) ? mgh_pkg::ST_RET_RD : mgh_pkg::ST_OUT_RD;
			mgh_pkg::ST_OUT_RD: state_d = mgh_pkg::ST_OUT_SEND;
			mgh_pkg::ST_OUT_SEND:
				if (m_tready)
					state_d = (out_bin_q == BW'(MULT_BINS - 1)) ?
						mgh_pkg::ST_IDLE : mgh_pkg::ST_OUT_RD;
			default: state_d = mgh_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory controls
	logic          ring_we;
	logic [AW-1:0] ring_wa, ring_ra;
	ring_entry_t   ring_wd;
	logic          hist_we;
	logic          out_phase;
	logic [BW-1:0] ra_addr, a_addr;
	always_comb begin
		s_tready = (state_q == mgh_pkg::ST_IDLE);
		m_tvalid = (state_q == mgh_pkg::ST_OUT_SEND);
		m_tlast  = (out_bin_q == BW'(MULT_BINS - 1));
		m_tdata  = {1'b0, overflow_q, mgh_pkg::FIELD_T_W'(latest_q), a_out, ra_out,
			6'(out_bin_q)};
		ring_we  = 1'b0;
		ring_wa  = ptr_q;
		ring_wd  = '{t: ring_rd_q.t, ra: ra_new, a: a_new};
		ring_ra  = (state_q == mgh_pkg::ST_RET_RD) ? head_q : ptr_q;
		if (state_q == mgh_pkg::ST_WALK_UPD) ring_we = 1'b1;
		if (state_q == mgh_pkg::ST_INSERT) begin
			ring_we = 1'b1;
			ring_wa = ins_addr;
			ring_wd = '{t: cur_t_q, ra: '0, a: '0};
		end
		hist_we = (state_q == mgh_pkg::ST_HIST_WR);
		// readout keeps reading its own bin so a stalled word holds
		out_phase = (state_q == mgh_pkg::ST_OUT_RD) || (state_q == mgh_pkg::ST_OUT_SEND);
		ra_addr = out_phase ? out_bin_q : ra_bin_q;
		a_addr  = out_phase ? out_bin_q : a_bin_q;
	end

	// pending ring memory
	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[ring_wa] <= ring_wd;
		ring_rd_q <= ring_mem[ring_ra];
	end

	// histogram memories, saturating increment
	always_ff @(posedge clk) begin
		if (hist_we && (ra_old != '1)) ra_mem[ra_bin_q] <= ra_old + HW'(1);
		if (hist_we && (a_old != '1))  a_mem[a_bin_q]   <= a_old + HW'(1);
		ra_rd_q <= ra_mem[ra_addr];
		a_rd_q  <= a_mem[a_addr];
	end

	// control and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mgh_pkg::ST_IDLE;
			mode_q     <= mgh_pkg::RET_WALK;
			head_q     <= '0;
			ptr_q      <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			prefix_q   <= 1'b0;
			latest_q   <= '0;
			cur_t_q    <= '0;
			overflow_q <= 1'b0;
			ra_bin_q   <= '0;
			a_bin_q    <= '0;
			out_bin_q  <= '0;
			ra_valid_q <= '0;
			a_valid_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				mgh_pkg::ST_IDLE:
					if (in_acc && !in_finish) begin
						cur_t_q  <= (t_in < latest_q) ? latest_q : t_in;
						latest_q <= (t_in < latest_q) ? latest_q : t_in;
						ptr_q    <= head_q;
						cnt_q    <= fill_q;
						prefix_q <= 1'b1;
					end else if (in_acc) begin
						mode_q <= mgh_pkg::RET_FINISH;
					end
				mgh_pkg::ST_WALK_UPD: begin
					if (cnt_sat) overflow_q <= 1'b1;
					ptr_q <= wrap_inc(ptr_q);
					cnt_q <= cnt_q - FW'(1);
					if (prefix_q && hit.retire) begin
						ra_bin_q <= ra_new;
						a_bin_q  <= a_new;
						mode_q   <= mgh_pkg::RET_WALK;
					end else begin
						prefix_q <= 1'b0;
					end
				end
				mgh_pkg::ST_CHECK_FULL:
					if (fill_q == FW'(PENDING_DEPTH)) begin
						overflow_q <= 1'b1;
						mode_q     <= mgh_pkg::RET_FORCE;
					end
				mgh_pkg::ST_RET_LATCH: begin
					ra_bin_q <= ring_rd_q.ra;
					a_bin_q  <= ring_rd_q.a;
				end
				mgh_pkg::ST_HIST_WR: begin
					if ((ra_old == '1) || (a_old == '1)) overflow_q <= 1'b1;
					ra_valid_q[ra_bin_q] <= 1'b1;
					a_valid_q[a_bin_q]   <= 1'b1;
					head_q <= wrap_inc(head_q);
					fill_q <= fill_q - FW'(1);
				end
				mgh_pkg::ST_INSERT: fill_q <= fill_q + FW'(1);
				mgh_pkg::ST_OUT_SEND:
					if (m_tready) begin
						if (out_bin_q == BW'(MULT_BINS - 1)) begin
							out_bin_q  <= '0;
							head_q     <= '0;
							fill_q     <= '0;
							latest_q   <= '0;
							overflow_q <= 1'b0;
							ra_valid_q <= '0;
							a_valid_q  <= '0;
						end else begin
							out_bin_q <= out_bin_q + BW'(1);
						end
					end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/mgh_checker.sv @@
// port-level checks of the multiplicity gate histogram, bound to the top level
`default_nettype none
module mgh_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [0:0]                    s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic                          m_tlast
);
	// a stalled readout word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("readout word dropped while stalled");

	// no input is taken during a readout
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during readout");

	// the final bin ends the readout
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("readout continues after final bin");

	// taking a finish word closes the input
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("input ready right after finish");
endmodule

bind multiplicity_gate_histogram mgh_checker u_mgh_checker (.*);
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench of the multiplicity gate histogram
`timescale 1ns / 100ps
module testbench;

	localparam int BINS  = mgh_pkg::MULT_BINS_DEF;
	localparam int DEPTH = mgh_pkg::PENDING_DEPTH_DEF;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int SETTLE_CYCLES = 600;

	typedef struct {
		logic [5:0]  bin;
		logic [31:0] ra_count;
		logic [31:0] a_count;
		logic [47:0] last_time;
		logic        ovf;
		logic        last;
	} readout_word_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [mgh_pkg::IN_DATA_W-1:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [mgh_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we;
	logic [mgh_pkg::IDX_W-1:0] cfg_index;
	logic [mgh_pkg::REG_W-1:0] cfg_wdata;

	multiplicity_gate_histogram uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [63:0] gate_pre, gate_long, gate_width;
	logic [47:0] pend_time [DEPTH];
	int pend_ra [DEPTH];
	int pend_a [DEPTH];
	int ring_head_m, ring_fill_m;
	logic [31:0] ra_hist [BINS];
	logic [31:0] a_hist [BINS];
	logic [47:0] latest_m;
	logic ovf_m;

	readout_word_t readout_queue[$];
	int mismatches;
	int idle_pct;
	int stall_pct;
	logic [47:0] cur_time;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void clear_run_m();
		for (int i = 0; i < BINS; i++) begin
			ra_hist[i] = '0;
			a_hist[i] = '0;
		end
		ring_head_m = 0;
		ring_fill_m = 0;
		latest_m = '0;
		ovf_m = 1'b0;
	endfunction

	function automatic void count_up(inout int c);
		if (c >= BINS - 1) ovf_m = 1'b1;
		else c++;
	endfunction

	function automatic void bin_up(inout logic [31:0] h);
		if (h == 32'hFFFF_FFFF) ovf_m = 1'b1;
		else h++;
	endfunction

	function automatic void retire_oldest();
		bin_up(ra_hist[pend_ra[ring_head_m]]);
		bin_up(a_hist[pend_a[ring_head_m]]);
		ring_head_m = (ring_head_m + 1) % DEPTH;
		ring_fill_m--;
	endfunction

	// one detector event into the predictor
	function automatic void predict_event(logic [47:0] t_in);
		logic [63:0] t, d;
		int k;
		t = 64'(t_in);
		if (t < 64'(latest_m)) t = 64'(latest_m);
		latest_m = t[47:0];
		for (int i = 0; i < ring_fill_m; i++) begin
			k = (ring_head_m + i) % DEPTH;
			d = t - 64'(pend_time[k]);
			if (d >= gate_pre && d - gate_pre <= gate_width) count_up(pend_ra[k]);
			if (d >= gate_long && d - gate_long <= gate_width) count_up(pend_a[k]);
		end
		while (ring_fill_m > 0) begin
			d = t - 64'(pend_time[ring_head_m]);
			if (d > gate_pre + gate_width && d > gate_long + gate_width) retire_oldest();
			else break;
		end
		if (ring_fill_m >= DEPTH) begin
			retire_oldest();
			ovf_m = 1'b1;
		end
		k = (ring_head_m + ring_fill_m) % DEPTH;
		pend_time[k] = t[47:0];
		pend_ra[k] = 0;
		pend_a[k] = 0;
		ring_fill_m++;
	endfunction

	// finish: retire everything, queue the readout, start afresh
	function automatic void predict_readout();
		readout_word_t w;
		while (ring_fill_m > 0) retire_oldest();
		for (int b = 0; b < BINS; b++) begin
			w.bin = b[5:0];
			w.ra_count = ra_hist[b];
			w.a_count = a_hist[b];
			w.last_time = latest_m;
			w.ovf = ovf_m;
			w.last = (b == BINS - 1);
			readout_queue.push_back(w);
		end
		clear_run_m();
	endfunction

	// send one word, with random sender gaps
	task automatic send_word(logic kind, logic [47:0] t);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = t;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == mgh_pkg::KIND_FINISH) predict_readout();
		else predict_event(t);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_event(logic [47:0] t);
		send_word(mgh_pkg::KIND_EVENT, t);
	endtask

	task automatic send_finish();
		send_word(mgh_pkg::KIND_FINISH, 48'($urandom));
	endtask

	// wait for the readout to drain and the block to settle
	task automatic wait_idle();
		while (readout_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [mgh_pkg::IDX_W-1:0] idx, logic [31:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			mgh_pkg::REG_PREDELAY:  gate_pre = 64'(value);
			mgh_pkg::REG_LONGDELAY: gate_long = 64'(value);
			mgh_pkg::REG_GATE:      gate_width = 64'(value);
			default: ;
		endcase
	endtask

	task automatic set_gates(logic [31:0] pre, logic [31:0] lng, logic [31:0] width);
		wait_idle();
		write_reg(mgh_pkg::REG_PREDELAY, pre);
		write_reg(mgh_pkg::REG_LONGDELAY, lng);
		write_reg(mgh_pkg::REG_GATE, width);
	endtask

	function automatic logic [47:0] add_sat(logic [47:0] a, logic [63:0] b);
		logic [63:0] s;
		s = 64'(a) + b;
		return (s > 64'(TIME_MAX)) ? TIME_MAX : s[47:0];
	endfunction

	// one run of events with random spacing, then finish
	task automatic play_run(int n_events, bit dense);
		logic [63:0] reach;
		int span, r;
		reach = ((gate_pre > gate_long) ? gate_pre : gate_long) + gate_width;
		span = (reach == 0) ? 4 : int'((reach >> 3) > 64'd1_000_000_000 ?
			64'd1_000_000_000 : (reach >> 3) + 1);
		if (dense) span = 0;
		cur_time = ($urandom_range(2) == 0) ? 48'({$urandom, $urandom}) :
			48'($urandom_range(1000));
		for (int i = 0; i < n_events; i++) begin
			r = $urandom_range(99);
			if (r < 5 && !dense) send_event(cur_time - 48'($urandom_range(50)));
			else begin
				if (r >= 20) cur_time = add_sat(cur_time, 64'($urandom_range(span)));
				send_event(cur_time);
			end
		end
		send_finish();
	endtask

	// equal times and register defaults, empty finish
	task automatic test_reset_defaults();
		send_finish();
		send_event(48'd0);
		send_event(48'd0);
		send_event(48'd1);
		send_event(48'd5);
		send_finish();
	endtask

	// widest gates, time extremes, out-of-order times
	task automatic test_extremes();
		set_gates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(48'd0);
		send_event(48'h0000_FFFF_FFFF);
		send_event(48'h0001_FFFF_FFFE);
		send_event(48'h0000_0000_0010);
		send_event(TIME_MAX);
		send_event(48'd3);
		send_finish();
		set_gates(32'd2, 32'd10, 32'd0);
		send_event(48'd100);
		send_event(48'd102);
		send_event(48'd103);
		send_event(48'd110);
		send_event(48'd111);
		send_event(48'd90);
		send_finish();
	endtask

	// random runs under several gate settings, one sender idle and receiver stall setting
	task automatic test_random_phase(int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		set_gates($urandom_range(20), $urandom_range(40, 200), $urandom_range(30));
		play_run($urandom_range(10, 20), 1'b0);
		// many events in one gate: counts saturate and the ring overflows
		set_gates(32'd0, 32'd0, 32'hFFFF_FFFF);
		play_run($urandom_range(66, 75), 1'b1);
		set_gates($urandom, $urandom, $urandom);
		play_run($urandom_range(3, 7), 1'b0);
		set_gates(32'd0, $urandom_range(8), $urandom_range(1, 6));
		play_run($urandom_range(3, 7), 1'b0);
	endtask

	// compare each readout word with the oldest expectation
	always @(posedge clk) begin
		readout_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (readout_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected readout word %h", m_tdata);
			end else begin
				w = readout_queue.pop_front();
				if (m_tdata[5:0] !== w.bin || m_tdata[37:6] !== w.ra_count ||
						m_tdata[69:38] !== w.a_count || m_tdata[117:70] !== w.last_time ||
						m_tdata[118] !== w.ovf || m_tdata[119] !== 1'b0 ||
						m_tlast !== w.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("bin %0d: exp ra %0d a %0d t %0d ovf %b last %b, got bin %0d ra %0d a %0d t %0d ovf %b last %b",
							w.bin, w.ra_count, w.a_count, w.last_time, w.ovf, w.last,
							m_tdata[5:0], m_tdata[37:6], m_tdata[69:38], m_tdata[117:70],
							m_tdata[118], m_tlast);
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		gate_pre = '0;
		gate_long = '0;
		gate_width = '0;
		cur_time = '0;
		clear_run_m();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_extremes();
		test_random_phase(0, 0);
		test_random_phase(53, 0);
		test_random_phase(0, 53);
		test_random_phase(16, 16);

		while (readout_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && readout_queue.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
